// ----- hdl/tbc_pkg.sv -----
// Tap tempo detector: shared types, constants and width helpers.
// No dependencies; every other file of the block imports this package.
package tbc_pkg;

   localparam int TBC_MAX_BEATS  = 16;
   localparam int TBC_MIN_BEATS  = 2;
   localparam int TBC_TIME_W     = 48;
   localparam int TBC_IVAL_W     = 26;
   localparam int TBC_METER_W    = 8;
   localparam int TBC_BTC_W      = 5;
   localparam int TBC_OFF_W      = 11;
   localparam int TBC_OUT_W      = 16;
   localparam int TBC_SCALE_W    = 37;
   localparam int TBC_QUO_W      = 17;
   localparam int TBC_QDEPTH     = 4;
   localparam int TBC_CSR_IDX_W  = 3;
   localparam int TBC_CSR_DATA_W = 11;

   // interval * meter_q4 above this means more than 3.001 s per beat
   localparam logic [TBC_IVAL_W+TBC_METER_W-1:0] TBC_RESET_LIMIT = 34'd48016000;
   localparam logic signed [15:0]                TBC_MIN_IVAL    = 16'sd1000;
   localparam logic signed [17:0]                TBC_TICK_US     = 18'sd100;
   localparam logic [TBC_OUT_W-1:0]              TBC_OUT_SAT     = 16'd50000;
   // 6000 centi-BPM-seconds in us, times 16 for the Q4.4 meter
   localparam logic [TBC_SCALE_W-1:0]            TBC_BPM_SCALE   = 37'd96000000000;
   localparam logic [9:0]                        TBC_MS_US       = 10'd1000;

   typedef enum logic [TBC_CSR_IDX_W-1:0] {
      CSR_BEATS = 3'd0,
      CSR_METER = 3'd1,
      CSR_COFF  = 3'd2,
      CSR_SOFF  = 3'd3,
      CSR_AUTO  = 3'd4
   } tbc_csr_idx_type;

   typedef struct packed {
      logic [TBC_BTC_W-1:0]   beats_to_count;
      logic [TBC_METER_W-1:0] meter_q4;
      logic [TBC_OFF_W-1:0]   count_offset;
      logic [TBC_OFF_W-1:0]   start_offset;
      logic                   autostart;
   } tbc_cfg_type;

   typedef struct packed {
      logic                 done;
      logic                 sat;
      logic [TBC_QUO_W-1:0] quo;
   } tbc_div_res_type;

   function automatic int tbc_idx_w(input int mb);
      return (mb > 2) ? $clog2(mb - 1) : 1;
   endfunction

   function automatic int tbc_bi_w(input int mb);
      return $clog2(mb + 1);
   endfunction

   function automatic int tbc_n_w(input int mb);
      return $clog2(mb);
   endfunction

   function automatic int tbc_cmd_w(input int mb);
      return TBC_IVAL_W + tbc_idx_w(mb) + 2;
   endfunction

   // a zero meter counts as the smallest step
   function automatic logic [TBC_METER_W-1:0] tbc_meter_eff(input logic [TBC_METER_W-1:0] m);
      return (m == '0) ? TBC_METER_W'(1) : m;
   endfunction

endpackage

// ----- hdl/tbc_intf.sv -----
// Tap tempo detector: request, response and register-write channels.
// Depends on tbc_pkg for field widths.
interface tbc_req_if import tbc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [TBC_TIME_W-1:0] tap_time_us;
   logic                  transport_rolling;
   modport source(output valid, tap_time_us, transport_rolling, input ready);
   modport sink(input valid, tap_time_us, transport_rolling, output ready);
endinterface

interface tbc_rsp_if import tbc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [TBC_OUT_W-1:0] bpm_centi;
   logic                 start_transport;
   logic [TBC_OUT_W-1:0] start_delay_ms;
   modport source(output valid, bpm_centi, start_transport, start_delay_ms, input ready);
   modport sink(input valid, bpm_centi, start_transport, start_delay_ms, output ready);
endinterface

interface tbc_csr_if import tbc_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [TBC_CSR_IDX_W-1:0]  index;
   logic [TBC_CSR_DATA_W-1:0] data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

// ----- hdl/tap_beat_counter_bpm_top.sv -----
// Tap tempo detector top level: register file, front end, queue, back end.
// Depends on tbc_pkg, tbc_intf, tbc_front, tbc_queue and tbc_back.
//
//   channel  dir  handshake    payload
//   req_if   in   valid/ready  tap_time_us[47:0], transport_rolling
//   rsp_if   out  valid/ready  bpm_centi[15:0], start_transport, start_delay_ms[15:0]
//   csr_if   in   valid/ready  index[2:0], data[10:0] (always ready)
//
// A tap passes through the front end's calc and classify states; req_if.ready drops
// meanwhile and stays low while a tap in classify waits for room in the 4-entry queue.
// A completed measurement of n intervals raises rsp_if.valid after its pop in the back end
// (store read, then two passes through the shared one-bit-per-cycle divider); a stored
// interval is written to the store from the idle state and gives no response.
// Reset is synchronous; the interval store needs no clearing pass.
// A stalled rsp_if holds the back end; the front keeps taking taps until the queue fills.
module tap_beat_counter_bpm_top import tbc_pkg::*; #(
   parameter int MAX_BEATS = TBC_MAX_BEATS
) (
   input logic        clock,
   input logic        reset,
   tbc_req_if.sink    req_if,
   tbc_rsp_if.source  rsp_if,
   tbc_csr_if.sink    csr_if
);

   localparam int CMD_W = tbc_cmd_w(MAX_BEATS);

   tbc_cfg_type       cfg_ff, cfg_in;
   logic              csr_wr;
   logic              q_push, q_pop, q_full, q_valid;
   logic [CMD_W-1:0]  q_wdata, q_rdata;

   assign csr_if.ready = 1'b1;
   assign csr_wr       = csr_if.valid && csr_if.ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         case (tbc_csr_idx_type'(csr_if.index))
            CSR_BEATS: cfg_in.beats_to_count = csr_if.data[TBC_BTC_W-1:0];
            CSR_METER: cfg_in.meter_q4       = csr_if.data[TBC_METER_W-1:0];
            CSR_COFF:  cfg_in.count_offset   = csr_if.data[TBC_OFF_W-1:0];
            CSR_SOFF:  cfg_in.start_offset   = csr_if.data[TBC_OFF_W-1:0];
            CSR_AUTO:  cfg_in.autostart      = csr_if.data[0];
            default:   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{beats_to_count: TBC_BTC_W'(4),
                     meter_q4:       TBC_METER_W'(16),
                     count_offset:   '0,
                     start_offset:   '0,
                     autostart:      1'b0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tbc_front #(
      .MAX_BEATS (MAX_BEATS)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .cfg    (cfg_ff),
      .q_full (q_full),
      .q_push (q_push),
      .q_data (q_wdata)
   );

   tbc_queue #(
      .W     (CMD_W),
      .DEPTH (TBC_QDEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .pop       (q_pop),
      .full      (q_full),
      .valid     (q_valid),
      .pop_data  (q_rdata)
   );

   tbc_back #(
      .MAX_BEATS (MAX_BEATS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .q_valid (q_valid),
      .q_data  (q_rdata),
      .q_pop   (q_pop),
      .rsp_if  (rsp_if)
   );

endmodule

// ----- hdl/tbc_front.sv -----
// Tap tempo detector front end: takes taps, forms intervals, tracks the beat index.
// Depends on tbc_pkg and tbc_req_if; pushes store/measure commands to tbc_queue.
module tbc_front import tbc_pkg::*; #(
   parameter int MAX_BEATS = TBC_MAX_BEATS
) (
   input  logic                           clock,
   input  logic                           reset,
   tbc_req_if.sink                        req_if,
   input  tbc_cfg_type                    cfg,
   input  logic                           q_full,
   output logic                           q_push,
   output logic [tbc_cmd_w(MAX_BEATS)-1:0] q_data
);

   localparam int IDX_W = tbc_idx_w(MAX_BEATS);
   localparam int BI_W  = tbc_bi_w(MAX_BEATS);
   localparam int FULL_W = TBC_TIME_W + 2;

   typedef enum logic [2:0] {
      F_IDLE = 3'b001,
      F_CALC = 3'b010,
      F_CLS  = 3'b100
   } tbc_fst_type;

   tbc_fst_type             state_ff, state_in;
   logic [BI_W-1:0]         beat_ff, beat_in;
   logic [TBC_TIME_W-1:0]   last_ff, last_in;
   logic [TBC_TIME_W-1:0]   diff_ff;
   logic                    rolling_ff;
   logic [TBC_IVAL_W-1:0]   ival_ff;
   logic                    pos_ff, big_ff, short_ff;

   logic                    accept;
   logic signed [17:0]      coff_us;
   logic signed [FULL_W-1:0] ival_full;
   logic [TBC_IVAL_W+TBC_METER_W-1:0] prod;
   logic                    too_long, first, measure;
   logic [BI_W-1:0]         target;
   logic [IDX_W-1:0]        idx;

   assign req_if.ready = (state_ff == F_IDLE);
   assign accept       = req_if.valid && req_if.ready;

   assign coff_us   = $signed(cfg.count_offset) * TBC_TICK_US;
   assign ival_full = (beat_ff > BI_W'(1))
                    ? $signed({2'b00, diff_ff}) - $signed({{(FULL_W-18){coff_us[17]}}, coff_us})
                    : '0;

   assign prod     = (TBC_IVAL_W+TBC_METER_W)'(ival_ff)
                   * (TBC_IVAL_W+TBC_METER_W)'(tbc_meter_eff(cfg.meter_q4));
   assign too_long = pos_ff && (big_ff || prod > TBC_RESET_LIMIT);
   assign first    = (beat_ff == BI_W'(1));
   assign measure  = (beat_ff >= target);
   assign idx      = IDX_W'(beat_ff - BI_W'(2));
   assign q_data   = {measure, rolling_ff, idx, ival_ff};

   always_comb begin
      if (cfg.beats_to_count < TBC_BTC_W'(TBC_MIN_BEATS)) begin
         target = BI_W'(TBC_MIN_BEATS);
      end else if (int'(cfg.beats_to_count) > MAX_BEATS) begin
         target = BI_W'(MAX_BEATS);
      end else begin
         target = BI_W'(cfg.beats_to_count);
      end
   end

   always_comb begin
      state_in = state_ff;
      beat_in  = beat_ff;
      last_in  = last_ff;
      q_push   = 1'b0;
      case (state_ff)
         F_IDLE: begin
            if (accept) begin
               last_in  = req_if.tap_time_us;
               state_in = F_CALC;
            end
         end
         F_CALC: begin
            state_in = F_CLS;
         end
         F_CLS: begin
            if (too_long) begin
               beat_in  = BI_W'(1);
               state_in = F_IDLE;
            end else if (first) begin
               beat_in  = BI_W'(2);
               state_in = F_IDLE;
            end else if (short_ff) begin
               state_in = F_IDLE;
            end else if (!q_full) begin
               // hold here while the queue is full
               q_push   = 1'b1;
               beat_in  = measure ? BI_W'(1) : beat_ff + BI_W'(1);
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         beat_ff  <= BI_W'(1);
         last_ff  <= '0;
      end else begin
         state_ff <= state_in;
         beat_ff  <= beat_in;
         last_ff  <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         diff_ff    <= req_if.tap_time_us - last_ff;
         rolling_ff <= req_if.transport_rolling;
      end
      if (state_ff == F_CALC) begin
         ival_ff  <= ival_full[TBC_IVAL_W-1:0];
         pos_ff   <= (ival_full > 0);
         big_ff   <= !ival_full[FULL_W-1] && (|ival_full[FULL_W-2:TBC_IVAL_W]);
         short_ff <= (ival_full <= FULL_W'(TBC_MIN_IVAL));
      end
   end

   a_too_long_restarts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == F_CLS && too_long) |=> (beat_ff == BI_W'(1)))
      else $error("beat index not restarted after an overlong interval");

endmodule

// ----- hdl/tbc_queue.sv -----
// Tap tempo detector command queue between front and back end.
// Depends on tbc_pkg for the default depth.
module tbc_queue import tbc_pkg::*; #(
   parameter int W     = 1,
   parameter int DEPTH = TBC_QDEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic [W-1:0] push_data,
   input  logic         pop,
   output logic         full,
   output logic         valid,
   output logic [W-1:0] pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [W-1:0]     mem_ff [DEPTH];
   logic [W-1:0]     rd_data_ff;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign valid    = (count_ff != '0);
   assign pop_data = rd_data_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
      // forward a request written into the slot that is read next
      if (push && wr_ptr_ff == rd_ptr_in) begin
         rd_data_ff <= push_data;
      end else begin
         rd_data_ff <= mem_ff[rd_ptr_in];
      end
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("request pushed into a full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> valid)
      else $error("request popped from an empty queue");

endmodule

// ----- hdl/tbc_div.sv -----
// Tap tempo detector restoring divider, one quotient bit per cycle, saturating.
// Depends on tbc_pkg for the quotient width and result struct.
module tbc_div import tbc_pkg::*; #(
   parameter int NUM_W = 1,
   parameter int DEN_W = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output tbc_div_res_type  res
);

   localparam int REM_W = DEN_W + TBC_QUO_W;
   localparam int CNT_W = $clog2(TBC_QUO_W);

   typedef enum logic [2:0] {
      D_IDLE = 3'b001,
      D_CHK  = 3'b010,
      D_RUN  = 3'b100
   } tbc_dst_type;

   tbc_dst_type          state_ff, state_in;
   logic                 done_ff, done_in;
   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [REM_W-1:0]     dsh_ff, dsh_in;
   logic [TBC_QUO_W-1:0] quo_ff, quo_in;
   logic                 sat_ff, sat_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 ge;

   assign ge  = (rem_ff >= dsh_ff);
   assign res = '{done: done_ff, sat: sat_ff, quo: quo_ff};

   always_comb begin
      state_in = state_ff;
      done_in  = 1'b0;
      rem_in   = rem_ff;
      dsh_in   = dsh_ff;
      quo_in   = quo_ff;
      sat_in   = sat_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         D_IDLE: begin
            if (start) begin
               rem_in   = REM_W'(num);
               dsh_in   = {den, {TBC_QUO_W{1'b0}}};
               sat_in   = 1'b0;
               state_in = D_CHK;
            end
         end
         D_CHK: begin
            // quotient would not fit: saturate
            if (ge) begin
               sat_in   = 1'b1;
               quo_in   = '1;
               done_in  = 1'b1;
               state_in = D_IDLE;
            end else begin
               dsh_in   = dsh_ff >> 1;
               quo_in   = '0;
               cnt_in   = CNT_W'(TBC_QUO_W - 1);
               state_in = D_RUN;
            end
         end
         D_RUN: begin
            if (ge) begin
               rem_in = rem_ff - dsh_ff;
            end
            quo_in = {quo_ff[TBC_QUO_W-2:0], ge};
            dsh_in = dsh_ff >> 1;
            if (cnt_ff == '0) begin
               done_in  = 1'b1;
               state_in = D_IDLE;
            end else begin
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         default: begin
            state_in = D_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      quo_ff <= quo_in;
      sat_ff <= sat_in;
      cnt_ff <= cnt_in;
   end

   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> (state_ff == D_IDLE && !done_ff))
      else $error("divider started while busy");

endmodule

// ----- hdl/tbc_back.sv -----
// Tap tempo detector back end: interval store, mean, tempo and start delay.
// Depends on tbc_pkg, tbc_rsp_if and tbc_div; pops commands from tbc_queue.
module tbc_back import tbc_pkg::*; #(
   parameter int MAX_BEATS = TBC_MAX_BEATS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  tbc_cfg_type                     cfg,
   input  logic                            q_valid,
   input  logic [tbc_cmd_w(MAX_BEATS)-1:0] q_data,
   output logic                            q_pop,
   tbc_rsp_if.source                       rsp_if
);

   localparam int IDX_W = tbc_idx_w(MAX_BEATS);
   localparam int N_W   = tbc_n_w(MAX_BEATS);
   localparam int DEPTH = MAX_BEATS - 1;
   localparam int SUM_W = TBC_IVAL_W + N_W;
   localparam int DEN_W = SUM_W + TBC_METER_W;
   localparam int NUM_W = TBC_SCALE_W + N_W;
   localparam int DLY_W = TBC_QUO_W + 3;

   typedef enum logic [5:0] {
      B_IDLE = 6'b000001,
      B_SUM  = 6'b000010,
      B_MUL  = 6'b000100,
      B_BPM  = 6'b001000,
      B_DLY  = 6'b010000,
      B_OUT  = 6'b100000
   } tbc_bst_type;

   tbc_bst_type           state_ff, state_in;
   logic [TBC_IVAL_W-1:0] store_mem [DEPTH];
   logic [TBC_IVAL_W-1:0] rd_data_ff;
   logic                  rd_vld_ff, rd_vld_in;
   logic [N_W-1:0]        cnt_ff, cnt_in;
   logic [N_W-1:0]        n_ff, n_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [NUM_W-1:0]      num_ff, num_in;
   logic [DEN_W-1:0]      den_ff, den_in;
   logic                  go_ff, go_in;
   logic                  rolling_ff, rolling_in;
   logic [TBC_OUT_W-1:0]  bpm_ff, bpm_in;
   logic                  start_ff, start_in;
   logic [TBC_OUT_W-1:0]  delay_ff, delay_in;

   logic [TBC_IVAL_W-1:0] q_ival;
   logic [IDX_W-1:0]      q_idx;
   logic                  q_rolling, q_measure;
   logic                  rd_en;
   tbc_div_res_type       div_res;
   logic signed [DLY_W-1:0] dly;
   logic [TBC_OUT_W-1:0]  dly_sat;

   assign q_ival    = q_data[TBC_IVAL_W-1:0];
   assign q_idx     = q_data[TBC_IVAL_W +: IDX_W];
   assign q_rolling = q_data[TBC_IVAL_W + IDX_W];
   assign q_measure = q_data[TBC_IVAL_W + IDX_W + 1];

   tbc_div #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (go_ff),
      .num   (num_ff),
      .den   (den_ff),
      .res   (div_res)
   );

   // mean ms plus both trims, clamped to [0, 50000]
   assign dly = $signed({3'b000, div_res.quo})
              + $signed({{(DLY_W-TBC_OFF_W){cfg.count_offset[TBC_OFF_W-1]}}, cfg.count_offset})
              + $signed({{(DLY_W-TBC_OFF_W){cfg.start_offset[TBC_OFF_W-1]}}, cfg.start_offset});

   always_comb begin
      if (dly[DLY_W-1]) begin
         dly_sat = '0;
      end else if (dly[DLY_W-2:0] > (DLY_W-1)'(TBC_OUT_SAT)) begin
         dly_sat = TBC_OUT_SAT;
      end else begin
         dly_sat = dly[TBC_OUT_W-1:0];
      end
   end

   assign rsp_if.valid           = (state_ff == B_OUT);
   assign rsp_if.bpm_centi       = bpm_ff;
   assign rsp_if.start_transport = start_ff;
   assign rsp_if.start_delay_ms  = delay_ff;

   always_comb begin
      state_in   = state_ff;
      rd_vld_in  = 1'b0;
      rd_en      = 1'b0;
      cnt_in     = cnt_ff;
      n_in       = n_ff;
      sum_in     = sum_ff;
      num_in     = num_ff;
      den_in     = den_ff;
      go_in      = 1'b0;
      rolling_in = rolling_ff;
      bpm_in     = bpm_ff;
      start_in   = start_ff;
      delay_in   = delay_ff;
      q_pop      = 1'b0;
      case (state_ff)
         B_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (q_measure) begin
                  n_in       = N_W'(q_idx) + N_W'(1);
                  cnt_in     = '0;
                  sum_in     = '0;
                  rolling_in = q_rolling;
                  state_in   = B_SUM;
               end
            end
         end
         B_SUM: begin
            // one store read per cycle; the read data is registered before it is summed
            rd_en     = (cnt_ff != n_ff);
            rd_vld_in = rd_en;
            if (rd_en) begin
               cnt_in = cnt_ff + N_W'(1);
            end
            if (rd_vld_ff) begin
               sum_in = sum_ff + SUM_W'(rd_data_ff);
            end
            if (!rd_en && !rd_vld_ff) begin
               state_in = B_MUL;
            end
         end
         B_MUL: begin
            sum_in   = (sum_ff == '0) ? SUM_W'(1) : sum_ff;
            den_in   = DEN_W'(sum_in) * DEN_W'(tbc_meter_eff(cfg.meter_q4));
            num_in   = NUM_W'(TBC_BPM_SCALE) * NUM_W'(n_ff);
            go_in    = 1'b1;
            state_in = B_BPM;
         end
         B_BPM: begin
            if (div_res.done) begin
               bpm_in   = (div_res.sat || div_res.quo > TBC_QUO_W'(TBC_OUT_SAT))
                        ? TBC_OUT_SAT : div_res.quo[TBC_OUT_W-1:0];
               num_in   = NUM_W'(sum_ff);
               den_in   = DEN_W'(n_ff) * DEN_W'(TBC_MS_US);
               go_in    = 1'b1;
               state_in = B_DLY;
            end
         end
         B_DLY: begin
            if (div_res.done) begin
               start_in = cfg.autostart && !rolling_ff;
               delay_in = start_in ? dly_sat : '0;
               state_in = B_OUT;
            end
         end
         B_OUT: begin
            if (rsp_if.ready) begin
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= B_IDLE;
         rd_vld_ff <= 1'b0;
         go_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= rd_vld_in;
         go_ff     <= go_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff     <= cnt_in;
      n_ff       <= n_in;
      sum_ff     <= sum_in;
      num_ff     <= num_in;
      den_ff     <= den_in;
      rolling_ff <= rolling_in;
      bpm_ff     <= bpm_in;
      start_ff   <= start_in;
      delay_ff   <= delay_in;
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         store_mem[q_idx] <= q_ival;
      end
      if (rd_en) begin
         rd_data_ff <= store_mem[IDX_W'(cnt_ff)];
      end
   end

   a_result_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (bpm_ff <= TBC_OUT_SAT && delay_ff <= TBC_OUT_SAT
                        && (start_ff || delay_ff == '0)))
      else $error("result fields out of range");

endmodule

// ----- dv/tap_beat_counter_bpm_checker.sv -----
// Tempo checker: watches the tap, tempo and register channels of the tap tempo detector,
// predicts every tempo result from its own copy of state and settings and compares.
// Depends on tbc_pkg and the channel interfaces in tbc_intf.
module tap_beat_counter_bpm_checker import tbc_pkg::*; #(
   parameter int MAX_BEATS = TBC_MAX_BEATS
) (
   input  logic clock,
   input  logic reset,
   tbc_req_if   req_if,
   tbc_rsp_if   rsp_if,
   tbc_csr_if   csr_if,
   output int   mismatches,
   output int   pending
);

   localparam longint unsigned LONG_TAP_LIMIT = 64'd48016000;
   localparam longint          SHORT_TAP_US   = 1000;
   localparam longint          TEMPO_SAT      = 50000;
   // 60 s * 100 centi * 1e6 us, times 16 for the Q4.4 meter
   localparam longint unsigned CENTI_BPM_Q4   = 64'd96000000000;

   typedef struct packed {
      logic [15:0] bpm;
      logic        start;
      logic [15:0] delay;
   } tempo_result_type;

   tempo_result_type tempo_expect_q[$];

   logic [4:0]  beats_cfg;
   logic [7:0]  meter_cfg;
   logic [10:0] coff_cfg;
   logic [10:0] soff_cfg;
   logic        auto_cfg;

   int          beat_idx;
   logic [47:0] last_tap;
   logic [25:0] interval_mem[MAX_BEATS-1];

   function automatic void predict_tempo(input logic [47:0] now, input logic rolling);
      logic [47:0]      elapsed;
      longint           ival;
      longint           coff;
      longint           delay;
      longint unsigned  meff;
      longint unsigned  sum;
      longint unsigned  bpm;
      int               target;
      int               n;
      tempo_result_type res;
      meff   = (meter_cfg == '0) ? 64'd1 : 64'(meter_cfg);
      target = int'(beats_cfg);
      if (target < 2) target = 2;
      if (target > MAX_BEATS) target = MAX_BEATS;
      coff    = longint'($signed(coff_cfg));
      elapsed = now - last_tap;
      ival    = (beat_idx > 1) ? longint'(elapsed) - coff * 100 : 0;
      last_tap = now;

      // too long a gap restarts the measurement
      if (ival > 0 && longint'(unsigned'(ival)) * meff > LONG_TAP_LIMIT) begin
         beat_idx = 1;
         return;
      end
      // drop bounces and negative intervals
      if (beat_idx > 1 && ival <= SHORT_TAP_US) return;

      if (beat_idx > 1 && beat_idx - 2 < MAX_BEATS - 1) interval_mem[beat_idx-2] = ival[25:0];
      if (beat_idx < target) begin
         beat_idx++;
         return;
      end

      n = beat_idx - 1;
      if (n > MAX_BEATS - 1) n = MAX_BEATS - 1;
      if (n == 0) n = 1;
      sum = 0;
      for (int i = 0; i < n; i++) sum += 64'(interval_mem[i]);
      if (sum == 0) sum = 1;

      bpm = CENTI_BPM_Q4 * 64'(n) / (sum * meff);
      if (bpm > 64'(TEMPO_SAT)) bpm = 64'(TEMPO_SAT);
      res.bpm   = bpm[15:0];
      res.start = auto_cfg && !rolling;
      res.delay = '0;
      if (res.start) begin
         delay = longint'(sum / (64'(n) * 64'd1000)) + coff + longint'($signed(soff_cfg));
         if (delay < 0) delay = 0;
         if (delay > TEMPO_SAT) delay = TEMPO_SAT;
         res.delay = delay[15:0];
      end
      tempo_expect_q.push_back(res);
      beat_idx = 1;
   endfunction

   always @(posedge clock) begin
      tempo_result_type want;
      if (reset) begin
         beats_cfg  = 5'd4;
         meter_cfg  = 8'd16;
         coff_cfg   = '0;
         soff_cfg   = '0;
         auto_cfg   = 1'b0;
         beat_idx   = 1;
         last_tap   = '0;
         mismatches = 0;
         tempo_expect_q.delete();
      end else begin
         if (csr_if.valid && csr_if.ready) begin
            case (csr_if.index)
               CSR_BEATS: beats_cfg = csr_if.data[4:0];
               CSR_METER: meter_cfg = csr_if.data[7:0];
               CSR_COFF:  coff_cfg  = csr_if.data;
               CSR_SOFF:  soff_cfg  = csr_if.data;
               CSR_AUTO:  auto_cfg  = csr_if.data[0];
               default: ;
            endcase
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (tempo_expect_q.size() == 0) begin
               if (mismatches < 10)
                  $display("unexpected tempo result: bpm=%0d start=%0b delay=%0d",
                           rsp_if.bpm_centi, rsp_if.start_transport, rsp_if.start_delay_ms);
               mismatches++;
            end else begin
               want = tempo_expect_q.pop_front();
               if (rsp_if.bpm_centi !== want.bpm || rsp_if.start_transport !== want.start ||
                   rsp_if.start_delay_ms !== want.delay) begin
                  if (mismatches < 10) begin
                     $write("tempo mismatch: expected bpm=%0d start=%0b delay=%0d, ",
                            want.bpm, want.start, want.delay);
                     $display("got bpm=%0d start=%0b delay=%0d", rsp_if.bpm_centi,
                              rsp_if.start_transport, rsp_if.start_delay_ms);
                  end
                  mismatches++;
               end
            end
         end
         if (req_if.valid && req_if.ready)
            predict_tempo(req_if.tap_time_us, req_if.transport_rolling);
      end
      pending = tempo_expect_q.size();
   end

endmodule

// ----- dv/tap_beat_counter_bpm_top_test.sv -----
// Testbench top for the tap tempo detector: clock, reset, tap and register stimulus,
// response back-pressure and the verdict. Depends on tbc_pkg, tbc_intf,
// tap_beat_counter_bpm_top and tap_beat_counter_bpm_checker.
module tap_beat_counter_bpm_top_test;
   import tbc_pkg::*;

   localparam int PHASES        = 8;
   localparam int TAPS_PER_PHASE = 175;
   localparam int SETTLE_CYCLES = 100;
   localparam int LONG_HOLD     = 1500;

   logic clock;
   logic reset;
   int   mismatches;
   int   pending;

   tbc_req_if req_if();
   tbc_rsp_if rsp_if();
   tbc_csr_if csr_if();

   tap_beat_counter_bpm_top uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   tap_beat_counter_bpm_checker tempo_chk (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .rsp_if     (rsp_if),
      .csr_if     (csr_if),
      .mismatches (mismatches),
      .pending    (pending)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   int          burst_left   = 0;
   logic [47:0] tap_clock    = '0;
   int          tb_meter     = 16;
   int          tb_coff      = 0;
   bit          hold_rsp_req = 1'b0;

   task automatic send_tap(input logic [47:0] stamp, input logic rolling);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
         burst_left = $urandom_range(1, 40);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_if.valid             <= 1'b1;
      req_if.tap_time_us       <= stamp;
      req_if.transport_rolling <= rolling;
      do @(posedge clock); while (!req_if.ready);
      burst_left--;
      tap_clock = stamp;
   endtask

   task automatic tap_after(input longint delta_us, input logic rolling);
      send_tap(tap_clock + 48'(delta_us), rolling);
   endtask

   task automatic write_reg(input tbc_csr_idx_type idx, input logic [10:0] value);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      do @(posedge clock); while (!csr_if.ready);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // unused upper data bits carry random values
   task automatic apply_settings(input logic [4:0] beats, input logic [7:0] meter,
                                 input logic [10:0] coff, input logic [10:0] soff,
                                 input logic auto_on);
      write_reg(CSR_BEATS, {6'($urandom), beats});
      write_reg(CSR_METER, {3'($urandom), meter});
      write_reg(CSR_COFF, coff);
      write_reg(CSR_SOFF, soff);
      write_reg(CSR_AUTO, {10'($urandom), auto_on});
      tb_meter = int'(meter);
      tb_coff  = int'($signed(coff));
   endtask

   // drop valid, wait for every tempo result and let trailing taps drain
   task automatic settle();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic random_taps(input int count);
      int          kind;
      longint      meff;
      longint      limit;
      longint      lo;
      longint      ival;
      logic [47:0] stamp;
      for (int i = 0; i < count; i++) begin
         kind  = $urandom_range(0, 99);
         meff  = (tb_meter == 0) ? 1 : tb_meter;
         limit = 48016000 / meff;
         lo    = (-tb_coff * 100 > 1001) ? -tb_coff * 100 : 1001;
         if (kind < 80) begin
            if (kind < 5) ival = limit;
            else if (kind < 10) ival = lo;
            else ival = longint'($urandom_range(int'(lo), int'(limit)));
         end else if (kind < 88) begin
            ival = longint'($urandom_range(0, 1005)) - 5;
         end else if (kind < 94) begin
            ival = limit + longint'($urandom_range(1, 2000000));
         end
         if (kind < 94) stamp = tap_clock + 48'(ival + longint'(tb_coff) * 100);
         else stamp = {16'($urandom), $urandom};
         send_tap(stamp, 1'($urandom));
      end
   endtask

   // response side: random stall pattern, plus one long hold-off on request
   initial begin
      int mode;
      int left;
      bit held;
      mode = 0;
      left = 0;
      held = 1'b0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp_req && !held) begin
            held = 1'b1;
            rsp_if.ready <= 1'b0;
            for (int c = 0; c < LONG_HOLD; c++) @(negedge clock);
         end
         if (left == 0) begin
            mode = $urandom_range(0, 3);
            left = $urandom_range(16, 200);
         end
         left--;
         case (mode)
            0: rsp_if.ready <= 1'b1;
            1: rsp_if.ready <= 1'($urandom);
            2: rsp_if.ready <= ($urandom_range(0, 3) == 0);
            default: rsp_if.ready <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   initial begin
      #3000000;
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      reset                    <= 1'b1;
      req_if.valid             <= 1'b0;
      req_if.tap_time_us       <= '0;
      req_if.transport_rolling <= 1'b0;
      csr_if.valid             <= 1'b0;
      csr_if.index             <= CSR_BEATS;
      csr_if.data              <= '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: bounce, wrap, exact limit, too long, saturated tempo
      send_tap(48'hFFFF_FFFF_F000, 1'b0);
      tap_after(1000, 1'b0);
      tap_after(5000, 1'b1);
      tap_after(3001000, 1'b0);
      tap_after(3001001, 1'b0);
      repeat (4) tap_after(1001, 1'($urandom));
      settle();

      // zero meter, most negative count trim, largest start trim
      apply_settings(5'd2, 8'd0, 11'(-1024), 11'd1023, 1'b1);
      tap_after(0, 1'b0);
      tap_after(40000000, 1'b0);
      tap_after(0, 1'b1);
      tap_after(400000, 1'b1);
      settle();

      // count below range, largest meter, start delay floored at zero
      apply_settings(5'd1, 8'd255, 11'(-1000), 11'(-1024), 1'b1);
      tap_after(0, 1'b0);
      tap_after(50000, 1'b0);
      tap_after(7, 1'b0);
      tap_after(88298, 1'b0);
      settle();

      // lower the count in the middle of a measurement
      apply_settings(5'd8, 8'd16, 11'd0, 11'd0, 1'b0);
      repeat (4) tap_after(500000, 1'b0);
      settle();
      write_reg(CSR_BEATS, 11'd3);
      tap_after(500000, 1'b0);
      settle();

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: apply_settings(5'd2, 8'd1, 11'(-1024), 11'(-1024), 1'b1);
            1: apply_settings(5'd16, 8'd255, 11'd1023, 11'd1023, 1'b1);
            3: apply_settings(5'd2, 8'($urandom), 11'($urandom), 11'($urandom), 1'($urandom));
            default:
               apply_settings(($urandom_range(0, 9) == 0) ? 5'($urandom)
                                                          : 5'($urandom_range(2, 16)),
                              8'($urandom), 11'($urandom), 11'($urandom), 1'($urandom));
         endcase
         // stall the response side while taps keep coming
         if (p == 3) hold_rsp_req = 1'b1;
         random_taps(TAPS_PER_PHASE);
         settle();
      end

      if (mismatches == 0 && pending == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ----- tap_beat_counter_bpm_top.f -----
hdl/tbc_pkg.sv
hdl/tbc_intf.sv
hdl/tbc_front.sv
hdl/tbc_queue.sv
hdl/tbc_div.sv
hdl/tbc_back.sv
hdl/tap_beat_counter_bpm_top.sv
dv/tap_beat_counter_bpm_checker.sv
dv/tap_beat_counter_bpm_top_test.sv
